/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/audmix_pkg.sv */
package audmix_pkg;

	localparam int unsigned DEPTH_DEF = 1024;

	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned POS_W    = 10;
	localparam int unsigned GAIN_W   = 9;
	localparam int unsigned FILL_W   = 11;
	localparam int unsigned ACC_W    = 32;
	localparam int unsigned PROD_W   = SAMPLE_W + GAIN_W + 1;
	localparam int unsigned EPOCH_W  = 8;

	localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);

	typedef enum logic {
		KIND_ACC  = 1'b0,
		KIND_READ = 1'b1
	} kind_t;

	typedef enum logic {
		CS_CLEAR = 1'b0,
		CS_RUN   = 1'b1
	} clr_state_t;

	// One accumulator slot as stored in the RAM.
	typedef struct packed {
		logic               v;
		logic [EPOCH_W-1:0] tag;
		logic [ACC_W-1:0]   acc;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

/* hw/rtl/audmix_ram.sv */
module audmix_ram #(
	parameter int unsigned AW    = 10,
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned DW    = 41
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	// Read returns the old word when the same address is written in this cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/audio_mix_accumulator.sv */
// Audio mixing accumulator. Takes one word per clock while busy is low: an
// accumulate word adds sample_in times an unsigned 1.8 gain into the slot at
// position, a read word returns that slot divided by 256 (toward zero, saturated
// to 16 bits) and clears it. Each read word passes the s1 stage and the result
// register, and done flags its result for exactly one cycle; the receiver cannot
// stall, so the result must be captured on that cycle. Throughput is one word
// per cycle while busy is low, set by a read-modify-write on a single-port-write
// RAM with a registered read and a forwarding register for back-to-back hits on
// one slot. After reset busy stays high while the RAM is swept clear. A read
// with last bumps an 8-bit pass counter; every 256th such read starts the same
// sweep, and busy is high from the cycle after that read until the sweep ends.
// master_gain is written through cfg_valid/cfg_data, always ready.
`include "assert_macros.svh"

module audio_mix_accumulator #(
	parameter int unsigned DEPTH = audmix_pkg::DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 kind,
	input  logic signed [audmix_pkg::SAMPLE_W-1:0] sample_in,
	input  logic [audmix_pkg::POS_W-1:0]         position,
	input  logic                                 use_own_gain,
	input  logic [audmix_pkg::GAIN_W-1:0]        own_gain,
	input  logic                                 last,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [audmix_pkg::GAIN_W-1:0]        cfg_data,
	output logic                                 done,
	output logic signed [audmix_pkg::SAMPLE_W-1:0] sample_out,
	output logic                                 in_range,
	output logic [audmix_pkg::FILL_W-1:0]        fill_length
);

	import audmix_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	function automatic logic signed [SAMPLE_W-1:0] sat_div256(input logic [ACC_W-1:0] acc);
		logic signed [ACC_W:0]   adj;
		logic signed [ACC_W-8:0] q;
		adj = $signed({acc[ACC_W-1], acc}) + (acc[ACC_W-1] ? 33'sd255 : 33'sd0);
		q = adj[ACC_W:8];
		if (q > 25'sd32767) begin
			return 16'sh7FFF;
		end else if (q < -25'sd32768) begin
			return 16'sh8000;
		end else begin
			return q[SAMPLE_W-1:0];
		end
	endfunction

	logic [GAIN_W-1:0] master_gain_q;
	logic              accept;
	logic              inside_in;
	logic [AW-1:0]     addr_in;
	logic [GAIN_W-1:0] gain_in;
	logic signed [PROD_W-1:0] prod_in;

	logic              v_s1;
	kind_t             kind_s1;
	logic [POS_W-1:0]  pos_s1;
	logic              last_s1;
	logic              inside_s1;
	logic [AW-1:0]     addr_s1;
	logic signed [PROD_W-1:0] prod_s1;
	logic              fwd_hit_s1;
	entry_t            fwd_q;
	logic              rd_s1;

	logic [EPOCH_W-1:0] epoch_q;
	logic [FILL_W-1:0]  fill_q;

	clr_state_t        state_q, state_d;
	logic [AW-1:0]     clr_addr_q;
	logic              clearing;
	logic              wrap_s1;

	logic [ENTRY_W-1:0] rdata;
	entry_t            base_word;
	logic              entry_live;
	logic [ACC_W-1:0]  base_acc;
	logic              s1_we;
	entry_t            s1_wdata;

	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	entry_t            mem_wdata;

	logic              done_q;
	logic signed [SAMPLE_W-1:0] sample_out_q;
	logic              in_range_q;
	logic [FILL_W-1:0] fill_length_q;

	// Configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_gain_q <= GAIN_RESET;
		end else if (cfg_valid) begin
			master_gain_q <= cfg_data;
		end
	end

	// Issue: RAM read and gain multiply
	assign accept    = start && !busy;
	assign inside_in = 32'(position) < DEPTH;
	assign addr_in   = AW'(position);
	assign gain_in   = use_own_gain ? own_gain : master_gain_q;
	assign prod_in   = PROD_W'(sample_in) * PROD_W'($signed({1'b0, gain_in}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1    <= kind_t'(kind);
			pos_s1     <= position;
			last_s1    <= last;
			inside_s1  <= inside_in;
			addr_s1    <= addr_in;
			prod_s1    <= prod_in;
			// the RAM returns the stale word when the slot is written this cycle
			fwd_hit_s1 <= s1_we && (addr_s1 == addr_in);
		end
		if (s1_we) begin
			fwd_q <= s1_wdata;
		end
	end

	audmix_ram #(
		.AW    (AW),
		.DEPTH (DEPTH),
		.DW    (ENTRY_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (addr_in),
		.rdata (rdata)
	);

	// Modify and write back
	always_comb begin
		base_word  = fwd_hit_s1 ? fwd_q : entry_t'(rdata);
		entry_live = base_word.v && (base_word.tag == epoch_q);
		base_acc   = (entry_live && inside_s1) ? base_word.acc : '0;
		s1_we      = v_s1 && inside_s1;
		s1_wdata.tag = epoch_q;
		if (kind_s1 == KIND_ACC) begin
			s1_wdata.v   = 1'b1;
			s1_wdata.acc = base_acc + ACC_W'(prod_s1);
		end else begin
			s1_wdata.v   = 1'b0;
			s1_wdata.acc = base_acc;
		end
	end

	assign mem_we    = clearing || s1_we;
	assign mem_waddr = clearing ? clr_addr_q : addr_s1;
	assign mem_wdata = clearing ? entry_t'('0) : s1_wdata;

	// Fill length and pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			epoch_q <= '0;
		end else if (v_s1) begin
			if (kind_s1 == KIND_ACC) begin
				if (inside_s1 && (fill_q < ({1'b0, pos_s1} + FILL_W'(1)))) begin
					fill_q <= {1'b0, pos_s1} + FILL_W'(1);
				end
			end else if (last_s1) begin
				fill_q  <= '0;
				epoch_q <= epoch_q + EPOCH_W'(1);
			end
		end
	end

	// Result register
	assign rd_s1 = v_s1 && (kind_s1 == KIND_READ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s1 && (kind_s1 == KIND_READ);
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && (kind_s1 == KIND_READ)) begin
			sample_out_q  <= sat_div256(base_acc);
			in_range_q    <= {1'b0, pos_s1} < fill_q;
			fill_length_q <= fill_q;
		end
	end

	assign done        = done_q;
	assign sample_out  = sample_out_q;
	assign in_range    = in_range_q;
	assign fill_length = fill_length_q;

	// Clearing sweep after reset and on pass counter wrap
	assign wrap_s1 = v_s1 && (kind_s1 == KIND_READ) && last_s1 && (&epoch_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= CS_CLEAR;
			clr_addr_q <= '0;
		end else begin
			state_q <= state_d;
			if (clearing) begin
				clr_addr_q <= (clr_addr_q == AW'(DEPTH - 1)) ? '0 : clr_addr_q + AW'(1);
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		clearing = 1'b0;
		busy     = 1'b0;
		case (state_q)
			CS_CLEAR: begin
				clearing = 1'b1;
				busy     = 1'b1;
				if (clr_addr_q == AW'(DEPTH - 1)) begin
					state_d = CS_RUN;
				end
			end
			CS_RUN: begin
				// hold off the next word so the sweep owns the write port
				busy = wrap_s1;
				if (wrap_s1) begin
					state_d = CS_CLEAR;
				end
			end
			default: begin
				state_d = CS_CLEAR;
			end
		endcase
	end

	`ASSERT_IMPLIES(a_no_item_in_sweep, clk, arst_n, state_q == CS_CLEAR, !v_s1, "word in sweep")
	`ASSERT_NEXT(a_done_follows_read, clk, arst_n, rd_s1, done, "read word gave no result")
	`ASSERT_NEXT(a_no_done_otherwise, clk, arst_n, !rd_s1, !done, "result without a read word")
	`ASSERT_NEXT(a_last_clears_fill, clk, arst_n, rd_s1 && last_s1, fill_q == '0, "fill kept")

endmodule

/* tb/audio_mix_checker.sv */
`timescale 1ns / 100ps

module audio_mix_checker
	import audmix_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       busy,
	input  logic                       kind,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	input  logic [POS_W-1:0]           position,
	input  logic                       use_own_gain,
	input  logic [GAIN_W-1:0]          own_gain,
	input  logic                       last,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [GAIN_W-1:0]          cfg_data,
	input  logic                       done,
	input  logic signed [SAMPLE_W-1:0] sample_out,
	input  logic                       in_range,
	input  logic [FILL_W-1:0]          fill_length,
	output int                         mismatch_cnt,
	output int                         open_reads
);

	typedef struct {
		logic signed [SAMPLE_W-1:0] smp;
		logic                       inr;
		logic [FILL_W-1:0]          fill;
		logic [POS_W-1:0]           pos;
	} readout_t;

	logic [ACC_W-1:0]  mix_mem [DEPTH_DEF];
	bit                held [DEPTH_DEF];
	logic [FILL_W-1:0] fill_now;
	logic [GAIN_W-1:0] master_now;
	readout_t          readout_q [$];
	int                fails;

	// Divide by 256 toward zero, then clamp to the 16-bit sample range.
	function automatic logic signed [SAMPLE_W-1:0] scale_down(input logic [ACC_W-1:0] a);
		int q;
		q = $signed(a) / 256;
		if (q < -32768)
			q = -32768;
		else if (q > 32767)
			q = 32767;
		return q[SAMPLE_W-1:0];
	endfunction

	task automatic mix_apply();
		int       smp_v;
		int       gain_v;
		int       prod;
		readout_t r;
		if (kind == KIND_ACC) begin
			smp_v = sample_in;
			gain_v = use_own_gain ? own_gain : master_now;
			prod = smp_v * gain_v;
			// an entry not held since the last read starts from zero
			mix_mem[position] = (held[position] ? mix_mem[position] : '0) + ACC_W'(prod);
			held[position] = 1'b1;
			if (fill_now < FILL_W'(position) + FILL_W'(1))
				fill_now = FILL_W'(position) + FILL_W'(1);
		end else begin
			r.smp = '0;
			if (held[position]) begin
				r.smp = scale_down(mix_mem[position]);
				held[position] = 1'b0;
			end
			r.inr = FILL_W'(position) < fill_now;
			r.fill = fill_now;
			r.pos = position;
			readout_q.insert(readout_q.size(), r);
			if (last) begin
				fill_now = '0;
				foreach (held[i])
					held[i] = 1'b0;
			end
		end
	endtask

	task automatic check_readout();
		readout_t want;
		if (readout_q.size() == 0) begin
			fails++;
			if (fails <= 10)
				$display("unexpected readout word: sample %0d in_range %0b fill %0d",
					sample_out, in_range, fill_length);
			return;
		end
		want = readout_q.pop_front();
		if (sample_out !== want.smp || in_range !== want.inr || fill_length !== want.fill) begin
			fails++;
			if (fails <= 10)
				$display({"readout pos %0d: expected sample %0d in_range %0b fill %0d,",
					" got sample %0d in_range %0b fill %0d"},
					want.pos, want.smp, want.inr, want.fill,
					sample_out, in_range, fill_length);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_now = GAIN_RESET;
			fill_now = '0;
			foreach (held[i])
				held[i] = 1'b0;
			readout_q.delete();
		end else begin
			if (done)
				check_readout();
			if (cfg_valid && cfg_ready)
				master_now = cfg_data;
			if (start && !busy)
				mix_apply();
		end
		mismatch_cnt <= fails;
		open_reads <= readout_q.size();
	end

endmodule

/* tb/audio_mix_accumulator_test.sv */
`timescale 1ns / 100ps

module audio_mix_accumulator_test;
	import audmix_pkg::*;

	localparam int CYCLE_LIMIT = 150000;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       start = 1'b0;
	logic                       busy;
	logic                       kind = KIND_ACC;
	logic signed [SAMPLE_W-1:0] sample_in = '0;
	logic [POS_W-1:0]           position = '0;
	logic                       use_own_gain = 1'b0;
	logic [GAIN_W-1:0]          own_gain = '0;
	logic                       last = 1'b0;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [GAIN_W-1:0]          cfg_data = '0;
	logic                       done;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic                       in_range;
	logic [FILL_W-1:0]          fill_length;
	int                         mismatch_cnt;
	int                         open_reads;

	int cycles = 0;
	int idle_pct = 14;
	int words_sent = 0;
	int last_reads = 0;
	bit seen [DEPTH_DEF];
	int seen_q [$];

	audio_mix_accumulator u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.sample_in(sample_in), .position(position), .use_own_gain(use_own_gain),
		.own_gain(own_gain), .last(last), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data), .done(done), .sample_out(sample_out), .in_range(in_range),
		.fill_length(fill_length)
	);

	audio_mix_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.sample_in(sample_in), .position(position), .use_own_gain(use_own_gain),
		.own_gain(own_gain), .last(last), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data), .done(done), .sample_out(sample_out), .in_range(in_range),
		.fill_length(fill_length), .mismatch_cnt(mismatch_cnt), .open_reads(open_reads)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic logic signed [SAMPLE_W-1:0] rnd_sample();
		case ($urandom_range(9))
			0: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
			1: return $urandom_range(1) ? -16'sd1 : 16'sd0;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic int rnd_gain();
		case ($urandom_range(9))
			0: return $urandom_range(1) ? 0 : 256;
			1: return 511;
			2, 3: return $urandom_range(257, 511);
			default: return $urandom_range(0, 256);
		endcase
	endfunction

	// Present one word, idling first at the current rate; returns once it is taken.
	task automatic issue(input kind_t k, input logic signed [SAMPLE_W-1:0] s, input int p,
			input bit own, input int g, input bit lst);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		start <= 1'b1;
		kind <= k;
		sample_in <= s;
		position <= POS_W'(p);
		use_own_gain <= own;
		own_gain <= GAIN_W'(g);
		last <= lst;
		do @(posedge clk); while (busy);
		words_sent++;
		if (k == KIND_READ && lst)
			last_reads++;
		if (k == KIND_ACC && !seen[p]) begin
			seen[p] = 1'b1;
			seen_q.insert(seen_q.size(), p);
		end
	endtask

	task automatic put_acc(input int p, input logic signed [SAMPLE_W-1:0] s, input bit own,
			input int g);
		issue(KIND_ACC, s, p, own, g, 1'($urandom_range(1)));
	endtask

	task automatic get_entry(input int p, input bit lst);
		issue(KIND_READ, SAMPLE_W'($urandom), p, 1'($urandom_range(1)),
			$urandom_range(0, 511), lst);
	endtask

	// Drain outstanding reads and let a trailing accumulate settle, then write.
	task automatic set_master(input int g);
		start <= 1'b0;
		@(posedge clk);
		while (open_reads != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
		while (busy)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= GAIN_W'(g);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Up to three sources mixed over a window, then read back in order.
	task automatic run_pass();
		int len;
		int base;
		int layers;
		len = ($urandom_range(9) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
		base = $urandom_range(0, DEPTH_DEF - len);
		layers = $urandom_range(1, 3);
		for (int l = 0; l < layers; l++)
			for (int i = 0; i < len; i++)
				if (l == 0 || $urandom_range(2) != 0)
					put_acc(base + i, rnd_sample(), 1'($urandom_range(1)), rnd_gain());
		for (int i = 0; i < len; i++)
			get_entry(base + i,
				(i == len - 1) ? ($urandom_range(4) != 0) : ($urandom_range(30) == 0));
	endtask

	task automatic run_tiny();
		int p;
		p = $urandom_range(0, DEPTH_DEF - 1);
		put_acc(p, rnd_sample(), 1'($urandom_range(1)), rnd_gain());
		if ($urandom_range(1))
			put_acc($urandom_range(0, DEPTH_DEF - 1), rnd_sample(), 1'($urandom_range(1)),
				rnd_gain());
		get_entry(p, 1'b1);
	endtask

	task automatic run_noise();
		repeat ($urandom_range(1, 6)) begin
			if ($urandom_range(1) || seen_q.size() == 0)
				put_acc($urandom_range(0, DEPTH_DEF - 1), rnd_sample(),
					1'($urandom_range(1)), rnd_gain());
			else
				get_entry(seen_q[$urandom_range(0, seen_q.size() - 1)], $urandom_range(3) == 0);
		end
	endtask

	task automatic run_random(input int goal);
		while (words_sent < goal) begin
			case ($urandom_range(19))
				0, 1, 2, 3: run_pass();
				4, 5, 6, 7, 8, 9, 10, 11, 12, 13: run_tiny();
				default: run_noise();
			endcase
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		set_master(256);

		// saturation both ways, gain above unity range, truncation toward zero
		put_acc(0, 16'sh7fff, 1'b1, 256);
		put_acc(0, 16'sh7fff, 1'b1, 511);
		put_acc(1023, 16'sh8000, 1'b0, 0);
		put_acc(1023, 16'sh8000, 1'b1, 511);
		put_acc(5, -16'sd1, 1'b1, 1);
		put_acc(6, -16'sd300, 1'b1, 256);
		put_acc(7, -16'sd257, 1'b1, 1);
		put_acc(8, 16'sd255, 1'b1, 1);
		put_acc(9, 16'sd1234, 1'b1, 0);
		put_acc(9, 16'sd1234, 1'b0, 0);
		get_entry(0, 1'b0);
		get_entry(1023, 1'b0);
		get_entry(5, 1'b0);
		get_entry(6, 1'b0);
		get_entry(7, 1'b0);
		get_entry(8, 1'b0);
		// entry left unread in a pass must count as zero afterwards
		put_acc(20, 16'sd4000, 1'b0, 0);
		get_entry(0, 1'b1);
		get_entry(6, 1'b0);
		put_acc(20, 16'sd100, 1'b0, 0);
		get_entry(20, 1'b0);
		get_entry(1023, 1'b1);
		get_entry(9, 1'b0);

		set_master(511);
		idle_pct = 14;
		run_random(400);

		set_master(0);
		idle_pct = 55;
		run_random(780);

		set_master($urandom_range(1, 255));
		idle_pct = 0;
		// enough pass ends to roll the pass counter over at least once
		while (last_reads < 270)
			run_tiny();
		run_random(1150);

		start <= 1'b0;
		@(posedge clk);
		while (open_reads != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0 && open_reads == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
